// File: design/plc_cnt_pkg.sv
`timescale 1ns / 1ps

package plc_cnt_pkg;

   // Bank sizes used as defaults for the top level.
   localparam int SHORT_COUNTERS_DEF = 128;
   localparam int LONG_COUNTERS_DEF  = 64;

   // Saturation limit of the 16-bit up counter.
   localparam logic [15:0] SHORT_LIMIT = 16'h7FFF;

   // Operation codes.
   localparam logic [1:0] OP_UP     = 2'd0;
   localparam logic [1:0] OP_RING   = 2'd1;
   localparam logic [1:0] OP_UPDOWN = 2'd2;
   localparam logic [1:0] OP_RESET  = 2'd3;

   typedef struct packed {
      logic [1:0]         op;
      logic [7:0]         counter_index;
      logic               power_flow;
      logic [15:0]        preset16;
      logic signed [31:0] preset32;
      logic               count_down;
   } req_type;

   typedef struct packed {
      logic signed [31:0] count_value;
      logic               contact;
      logic               index_error;
   } rsp_type;

   // One counter entry; a 16-bit counter keeps its value in the low half.
   typedef struct packed {
      logic        latch;
      logic        contact;
      logic [31:0] value;
   } entry_type;

endpackage

// File: design/plc_cnt_store.sv
`timescale 1ns / 1ps

module plc_cnt_store #(
   parameter int SHORT_COUNTERS = 128,
   parameter int LONG_COUNTERS  = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  logic [7:0]             rd_index,
   input  logic                   wr_en,
   input  logic [7:0]             wr_index,
   input  plc_cnt_pkg::entry_type wr_entry,
   output plc_cnt_pkg::entry_type rd_entry,
   output logic                   clearing
);
   import plc_cnt_pkg::*;

   localparam int SW   = (SHORT_COUNTERS > 1) ? $clog2(SHORT_COUNTERS) : 1;
   localparam int LW   = (LONG_COUNTERS > 1) ? $clog2(LONG_COUNTERS) : 1;
   localparam int MAXC = (SHORT_COUNTERS > LONG_COUNTERS) ? SHORT_COUNTERS : LONG_COUNTERS;
   localparam int CW   = $clog2(MAXC + 1);

   logic [17:0] short_mem [SHORT_COUNTERS];
   logic [33:0] long_mem  [LONG_COUNTERS];

   logic [17:0]   short_rd_ff;
   logic [33:0]   long_rd_ff;
   logic          long_sel_ff;
   logic          byp_ff;
   entry_type     byp_data_ff;
   logic          clr_ff;
   logic          clr_in;
   logic [CW-1:0] clr_cnt_ff;
   logic [CW-1:0] clr_cnt_in;

   logic          rd_long;
   logic          wr_long;
   logic [SW-1:0] rd_short_addr;
   logic [LW-1:0] rd_long_addr;
   logic [SW-1:0] wr_short_addr;
   logic [LW-1:0] wr_long_addr;
   entry_type     mem_entry;

   // Bank selection and addresses within each bank.
   always_comb begin
      rd_long       = {24'd0, rd_index} >= 32'(SHORT_COUNTERS);
      wr_long       = {24'd0, wr_index} >= 32'(SHORT_COUNTERS);
      rd_short_addr = SW'(rd_index);
      wr_short_addr = SW'(wr_index);
      rd_long_addr  = LW'({24'd0, rd_index} - 32'(SHORT_COUNTERS));
      wr_long_addr  = LW'({24'd0, wr_index} - 32'(SHORT_COUNTERS));
   end

   // Clearing pass after reset, one entry of each bank a cycle.
   always_comb begin
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == CW'(MAXC - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         clr_ff     <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   assign clearing = clr_ff;

   // Short bank: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (clr_ff) begin
         if (clr_cnt_ff < CW'(SHORT_COUNTERS)) begin
            short_mem[SW'(clr_cnt_ff)] <= '0;
         end
      end else if (wr_en && !wr_long) begin
         short_mem[wr_short_addr] <= {wr_entry.latch, wr_entry.contact, wr_entry.value[15:0]};
      end
      if (rd_en) begin
         short_rd_ff <= short_mem[rd_short_addr];
      end
   end

   // Long bank: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (clr_ff) begin
         if (clr_cnt_ff < CW'(LONG_COUNTERS)) begin
            long_mem[LW'(clr_cnt_ff)] <= '0;
         end
      end else if (wr_en && wr_long) begin
         long_mem[wr_long_addr] <= {wr_entry.latch, wr_entry.contact, wr_entry.value};
      end
      if (rd_en) begin
         long_rd_ff <= long_mem[rd_long_addr];
      end
   end

   // A read that meets a write to the same counter takes the new entry.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         long_sel_ff <= rd_long;
         byp_ff      <= wr_en && (wr_index == rd_index);
         byp_data_ff <= wr_entry;
      end
   end

   always_comb begin
      if (long_sel_ff) begin
         mem_entry.latch   = long_rd_ff[33];
         mem_entry.contact = long_rd_ff[32];
         mem_entry.value   = long_rd_ff[31:0];
      end else begin
         mem_entry.latch   = short_rd_ff[17];
         mem_entry.contact = short_rd_ff[16];
         mem_entry.value   = {16'd0, short_rd_ff[15:0]};
      end
      rd_entry = byp_ff ? byp_data_ff : mem_entry;
   end

endmodule

// File: design/plc_cnt_alu.sv
`timescale 1ns / 1ps

module plc_cnt_alu #(
   parameter int SHORT_COUNTERS = 128,
   parameter int LONG_COUNTERS  = 64
) (
   input  plc_cnt_pkg::req_type   req,
   input  plc_cnt_pkg::entry_type cur,
   output plc_cnt_pkg::entry_type nxt,
   output logic                   index_ok,
   output plc_cnt_pkg::rsp_type   rsp
);
   import plc_cnt_pkg::*;

   logic [31:0] idx_w;
   logic        in_short;
   logic        in_long;
   logic        rise;
   logic [15:0] v16;
   logic [15:0] v16_inc;
   logic [31:0] v32;

   // Check the counter number against the bank of the operation.
   always_comb begin
      idx_w    = {24'd0, req.counter_index};
      in_short = idx_w < 32'(SHORT_COUNTERS);
      in_long  = !in_short && (idx_w < 32'(SHORT_COUNTERS + LONG_COUNTERS));
      case (req.op)
         OP_UP, OP_RING: index_ok = in_short;
         OP_UPDOWN:      index_ok = in_long;
         default:        index_ok = in_short || in_long;
      endcase
   end

   // Counter update on a rising edge of power flow; a reset operation clears while power flow is high.
   always_comb begin
      rise    = req.power_flow && !cur.latch;
      v16     = cur.value[15:0];
      v16_inc = v16 + 16'd1;
      v32     = req.count_down ? cur.value - 32'd1 : cur.value + 32'd1;
      nxt     = cur;
      case (req.op)
         OP_UP: begin
            nxt.latch = req.power_flow;
            if (rise) begin
               if (v16 < SHORT_LIMIT) begin
                  nxt.value = {16'd0, v16_inc};
                  if (v16_inc >= req.preset16) begin
                     nxt.contact = 1'b1;
                  end
               end else if (v16 >= req.preset16) begin
                  nxt.contact = 1'b1;
               end
            end
         end
         OP_RING: begin
            nxt.latch = req.power_flow;
            if (rise) begin
               if (v16 == req.preset16) begin
                  nxt.value   = 32'd1;
                  nxt.contact = 1'b0;
               end else begin
                  nxt.value = {16'd0, v16_inc};
                  if (v16_inc >= req.preset16) begin
                     nxt.contact = 1'b1;
                  end
               end
            end
         end
         OP_UPDOWN: begin
            nxt.latch = req.power_flow;
            if (rise) begin
               nxt.value = v32;
               if (req.count_down) begin
                  nxt.contact = $signed(v32) <= req.preset32;
               end else begin
                  nxt.contact = $signed(v32) >= req.preset32;
               end
            end
         end
         default: begin
            if (req.power_flow) begin
               nxt.value   = '0;
               nxt.contact = 1'b0;
            end
         end
      endcase
   end

   // Result of the request.
   always_comb begin
      if (index_ok) begin
         rsp.count_value = nxt.value;
         rsp.contact     = nxt.contact;
         rsp.index_error = 1'b0;
      end else begin
         rsp.count_value = '0;
         rsp.contact     = 1'b0;
         rsp.index_error = 1'b1;
      end
   end

endmodule

// File: design/plc_counter_bank.sv
`timescale 1ns / 1ps
// Requests are held in the request register, responses in the result register.
// Throughput: one request per cycle unless rsp_stall or the clearing pass holds
// it; the counter entry is read from the bank memory at acceptance and written
// back at commit, with forwarding. Reset is synchronous and active high. After
// reset the block runs a clearing pass over both banks and stalls requests.

module plc_counter_bank #(
   parameter int SHORT_COUNTERS = plc_cnt_pkg::SHORT_COUNTERS_DEF,
   parameter int LONG_COUNTERS  = plc_cnt_pkg::LONG_COUNTERS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  plc_cnt_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output plc_cnt_pkg::rsp_type rsp_data
);
   import plc_cnt_pkg::*;

   logic      s1_valid_ff;
   logic      s1_valid_in;
   req_type   s1_req_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_ff;

   logic      clearing;
   logic      advance;
   logic      accept;
   logic      commit;
   logic      index_ok;
   entry_type cur_entry;
   entry_type nxt_entry;
   rsp_type   result;

   // Handshake and pipeline control.
   always_comb begin
      advance      = !rsp_valid_ff || !rsp_stall;
      req_stall    = clearing || (s1_valid_ff && !advance);
      accept       = req_valid && !req_stall;
      commit       = s1_valid_ff && advance;
      s1_valid_in  = accept || (s1_valid_ff && !commit);
      rsp_valid_in = commit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request register and result register.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_data;
      end
      if (commit) begin
         rsp_ff <= result;
      end
   end

   plc_cnt_store #(
      .SHORT_COUNTERS(SHORT_COUNTERS),
      .LONG_COUNTERS (LONG_COUNTERS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_index(req_data.counter_index),
      .wr_en   (commit && index_ok),
      .wr_index(s1_req_ff.counter_index),
      .wr_entry(nxt_entry),
      .rd_entry(cur_entry),
      .clearing(clearing)
   );

   plc_cnt_alu #(
      .SHORT_COUNTERS(SHORT_COUNTERS),
      .LONG_COUNTERS (LONG_COUNTERS)
   ) u_alu (
      .req     (s1_req_ff),
      .cur     (cur_entry),
      .nxt     (nxt_entry),
      .index_ok(index_ok),
      .rsp     (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: design/plc_cnt_checker.sv
`timescale 1ns / 1ps

module plc_cnt_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input plc_cnt_pkg::req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input plc_cnt_pkg::rsp_type rsp_data
);
   import plc_cnt_pkg::*;

   logic [1:0] pending_ff;
   logic [1:0] pending_in;
   logic       req_take;
   logic       rsp_take;

   // Requests accepted whose responses have not yet been taken.
   always_comb begin
      req_take   = req_valid && !req_stall;
      rsp_take   = rsp_valid && !rsp_stall;
      pending_in = pending_ff + {1'b0, req_take} - {1'b0, rsp_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // The block holds at most two requests in flight.
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two requests in flight");

   // No response appears without a request behind it.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without a request");

   // An index error response carries a zero value and an open contact.
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.index_error |-> rsp_data.count_value == 32'sd0 && !rsp_data.contact)
      else $error("index error response carries data");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // After reset no response is shown.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind plc_counter_bank plc_cnt_checker u_checker (.*);
